@@ rtl/core/lmc565_pkg.sv @@
// ----------------------------------------------------------------------------
// lmc565_pkg
// Shared types and constants of the lightmap combiner: register indexes,
// output modes, datapath widths and the saturate-to-byte helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lmc565_pkg;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 48;

    localparam logic [CFG_AW-1:0] REG_GAIN0 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MAPS  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_MODE  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_FULL  = 3'd6;

    localparam logic [CFG_DW-1:0] GAIN_RESET = 48'h0100_0100_0100;
    localparam logic [2:0]        MAPS_RESET = 3'd1;

    // Datapath widths
    localparam int SAMPLE_W = 24;    // one RGB888 sample
    localparam int GAIN_W   = 16;    // one 8.8 gain
    localparam int PROD_W   = 24;    // byte times gain
    localparam int PAIR_W   = 25;    // sum of two products
    localparam int SUM_W    = 26;    // sum of four products
    localparam int CH_W     = 18;    // channel after dropping the fraction
    localparam int NUM_W    = 26;    // channel times 255
    localparam int Q_W      = 8;     // rescaled channel
    localparam int TEXEL_W  = 16;

    typedef enum logic [1:0] {
        MODE_CLAMP = 2'd0,
        MODE_GRAY  = 2'd1,
        MODE_COLOR = 2'd2,
        MODE_ALPHA = 2'd3
    } mode_t;

    function automatic logic [Q_W-1:0] min255(input logic [CH_W-1:0] v);
        logic [Q_W-1:0] res;
        if (v > CH_W'(255))
            res = 8'hFF;
        else
            res = v[Q_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lightmap_combine_rgb565.sv @@
// ----------------------------------------------------------------------------
// lightmap_combine_rgb565
// Weights up to four lightmap style samples per texel, shapes the channels
// in one of four output modes and packs the texel as RGB565.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one texel per word: four RGB888 samples, map 0 in the
//   lowest bits. m_axis returns one RGB565 word per texel, in order.
//   cfg_wen/cfg_addr/cfg_data write the gains (index 0..3), maps in use (4),
//   output mode (5) and full bright (6); write only while no texel is in
//   flight. Other indexes are dropped.
// Throughput and stages:
//   One word per cycle sustained while m_axis_tready stays high. Stages:
//   gain multiply, pair add, final add, max and times-255, eight restoring
//   divide steps (one quotient bit per stage, used by the colored rescale
//   mode), output pack register.
// Reset:
//   Empties the pipeline and loads unity gains, one map, clamp mode, full
//   bright off. s_axis_tready is high right after reset.
// Stall:
//   Each stage holds while it is full and the stage after it holds; empty
//   stages keep taking words, so input is accepted until the whole pipeline
//   is full behind a stalled receiver. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module lightmap_combine_rgb565 #(
    parameter int MAX_MAPS = 4
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // configuration
    input  wire logic                                      cfg_wen,
    input  wire logic [lmc565_pkg::CFG_AW-1:0]             cfg_addr,
    input  wire logic [lmc565_pkg::CFG_DW-1:0]             cfg_data,
    // input stream
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // sample_map0 [23:0], sample_map1 [47:24], sample_map2 [71:48],
    // sample_map3 [95:72]
    input  wire logic [4*lmc565_pkg::SAMPLE_W-1:0]         s_axis_tdata,
    // output stream
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // texel_rgb565 [15:0]
    output logic [lmc565_pkg::TEXEL_W-1:0]                 m_axis_tdata
);

    import lmc565_pkg::*;

    // Stage indexes
    localparam int DIV_STEPS = Q_W;
    localparam int ST_MUL    = 0;
    localparam int ST_PAIR   = 1;
    localparam int ST_SUM    = 2;
    localparam int ST_PREP   = 3;
    localparam int ST_DIV0   = 4;
    localparam int ST_OUT    = ST_DIV0 + DIV_STEPS;
    localparam int NSTG      = ST_OUT + 1;
    localparam int NPAIR     = (MAX_MAPS + 1) / 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DW-1:0] gain_reg [MAX_MAPS];
    logic [2:0]        maps_reg;
    mode_t             mode_reg;
    logic              full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MAX_MAPS; m++)
            begin
                gain_reg[m] <= GAIN_RESET;
            end
            maps_reg <= MAPS_RESET;
            mode_reg <= MODE_CLAMP;
            full_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            // gains of maps the build does not have are dropped
            for (int m = 0; m < MAX_MAPS; m++)
            begin
                if (cfg_addr == REG_GAIN0 + CFG_AW'(m))
                    gain_reg[m] <= cfg_data;
            end
            if (cfg_addr == REG_MAPS)
                maps_reg <= cfg_data[2:0];
            if (cfg_addr == REG_MODE)
                mode_reg <= mode_t'(cfg_data[1:0]);
            if (cfg_addr == REG_FULL)
                full_reg <= cfg_data[0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or the stage after
    // it moves on. Valid bits ride along with the data.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;

    assign rdy[NSTG] = m_axis_tready;
    for (genvar k = 0; k < NSTG; k++)
    begin : g_rdy
        assign rdy[k] = m_axis_tready || !(&vld_reg[NSTG-1:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Multiply: every enabled map's byte times its 8.8 gain, per channel.
    // Channel 0 is red, 1 green, 2 blue.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod_reg [MAX_MAPS][3];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_MUL])
        begin
            for (int m = 0; m < MAX_MAPS; m++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (3'(m) < maps_reg)
                        prod_reg[m][c] <=
                            PROD_W'(s_axis_tdata[m*SAMPLE_W + 16 - 8*c +: 8])
                            * PROD_W'(gain_reg[m][32 - 16*c +: GAIN_W]);
                    else
                        prod_reg[m][c] <= '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pair add
    // ------------------------------------------------------------------
    logic [PAIR_W-1:0] pair_reg [NPAIR][3];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_PAIR])
        begin
            for (int p = 0; p < NPAIR; p++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (2*p + 1 < MAX_MAPS)
                        pair_reg[p][c] <= PAIR_W'(prod_reg[2*p][c])
                                        + PAIR_W'(prod_reg[(2*p+1) % MAX_MAPS][c]);
                    else
                        pair_reg[p][c] <= PAIR_W'(prod_reg[2*p][c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Final add, drop the fraction, full-bright override
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] sum [3];
    logic [CH_W-1:0]  ch_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = '0;
            for (int p = 0; p < NPAIR; p++)
            begin
                sum[c] = sum[c] + SUM_W'(pair_reg[p][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SUM])
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (full_reg)
                    ch_reg[c] <= CH_W'(255);
                else
                    ch_reg[c] <= sum[c][SUM_W-1:8];
            end
        end
    end

    // ------------------------------------------------------------------
    // Brightest channel and channel times 255 (dividend of the rescale)
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  mx_rg;
    logic [CH_W-1:0]  c_reg [3];
    logic [CH_W-1:0]  mx_reg;
    logic [NUM_W-1:0] num_reg [3];

    assign mx_rg = (ch_reg[0] > ch_reg[1]) ? ch_reg[0] : ch_reg[1];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_PREP])
        begin
            mx_reg <= (ch_reg[2] > mx_rg) ? ch_reg[2] : mx_rg;
            for (int c = 0; c < 3; c++)
            begin
                c_reg[c]   <= ch_reg[c];
                num_reg[c] <= (NUM_W'(ch_reg[c]) << 8) - NUM_W'(ch_reg[c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Non-divide results, chosen once in front of the divider and carried
    // along beside it.
    // ------------------------------------------------------------------
    logic [Q_W-1:0] alt0 [3];
    logic           usediv0;

    always_comb
    begin
        logic [Q_W-1:0] sat_mx;
        sat_mx = min255(mx_reg);
        unique case (mode_reg)
            MODE_CLAMP:
            begin
                for (int c = 0; c < 3; c++)
                    alt0[c] = min255(c_reg[c]);
            end
            MODE_GRAY:
            begin
                for (int c = 0; c < 3; c++)
                    alt0[c] = sat_mx;
            end
            MODE_COLOR:
            begin
                // brightest is at most 255: channels pass unchanged
                for (int c = 0; c < 3; c++)
                    alt0[c] = c_reg[c][Q_W-1:0];
            end
            MODE_ALPHA:
            begin
                for (int c = 0; c < 3; c++)
                    alt0[c] = 8'hFF - sat_mx;
            end
        endcase
        usediv0 = (mode_reg == MODE_COLOR) && (mx_reg > CH_W'(255));
    end

    // ------------------------------------------------------------------
    // Restoring divide c*255 / max, one quotient bit per stage, MSB first.
    // The quotient fits in 8 bits because no channel exceeds the max.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] rem_reg [DIV_STEPS][3];
    logic [Q_W-1:0]   q_reg   [DIV_STEPS][3];
    logic [CH_W-1:0]  dv_reg  [DIV_STEPS];
    logic [Q_W-1:0]   alt_reg [DIV_STEPS][3];
    logic             ud_reg  [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int BIT = DIV_STEPS - 1 - j;

        logic [NUM_W-1:0] rem_in [3];
        logic [Q_W-1:0]   q_in   [3];
        logic [CH_W-1:0]  dv_in;
        logic [Q_W-1:0]   alt_in [3];
        logic             ud_in;
        logic [NUM_W:0]   trial  [3];
        logic [Q_W-1:0]   q_next [3];
        logic [NUM_W-1:0] dsh;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c] = num_reg[c];
                    q_in[c]   = '0;
                    alt_in[c] = alt0[c];
                end
                dv_in = mx_reg;
                ud_in = usediv0;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c] = rem_reg[j-1][c];
                    q_in[c]   = q_reg[j-1][c];
                    alt_in[c] = alt_reg[j-1][c];
                end
                dv_in = dv_reg[j-1];
                ud_in = ud_reg[j-1];
            end
        end

        assign dsh = NUM_W'(dv_in) << BIT;

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                trial[c]       = {1'b0, rem_in[c]} - {1'b0, dsh};
                q_next[c]      = q_in[c];
                q_next[c][BIT] = !trial[c][NUM_W];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[ST_DIV0 + j])
            begin
                for (int c = 0; c < 3; c++)
                begin
                    // keep the difference where it did not borrow
                    rem_reg[j][c]      <= trial[c][NUM_W] ? rem_in[c] : trial[c][NUM_W-1:0];
                    q_reg[j][c]        <= q_next[c];
                    alt_reg[j][c]      <= alt_in[c];
                end
                dv_reg[j] <= dv_in;
                ud_reg[j] <= ud_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Select and pack RGB565
    // ------------------------------------------------------------------
    logic [Q_W-1:0]     fin [3];
    logic [TEXEL_W-1:0] texel_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            fin[c] = ud_reg[DIV_STEPS-1] ? q_reg[DIV_STEPS-1][c] : alt_reg[DIV_STEPS-1][c];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
            texel_reg <= {fin[0][7:3], fin[1][7:2], fin[2][7:3]};
    end

    assign m_axis_tdata = texel_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty output stage must never block the input.
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled while output stage is empty");

    // No channel exceeds the brightest one.
    a_max_bounds: assert property (
        @(posedge clk) disable iff (!rst_n)
        vld_reg[ST_PREP] |-> (c_reg[0] <= mx_reg) && (c_reg[1] <= mx_reg)
                             && (c_reg[2] <= mx_reg)
    ) else $error("channel above computed maximum");

    // After the last divide step the remainder is below the divisor.
    a_div_rem: assert property (
        @(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_OUT-1] && ud_reg[DIV_STEPS-1]) |->
            (rem_reg[DIV_STEPS-1][0] < NUM_W'(dv_reg[DIV_STEPS-1]))
            && (rem_reg[DIV_STEPS-1][1] < NUM_W'(dv_reg[DIV_STEPS-1]))
            && (rem_reg[DIV_STEPS-1][2] < NUM_W'(dv_reg[DIV_STEPS-1]))
    ) else $error("rescale divide left remainder not below divisor");

endmodule

`default_nettype wire

@@ bench/lmc565_checker.sv @@
// ----------------------------------------------------------------------------
// lmc565_checker
// Watches the configuration port and both streams of the lightmap combiner.
// Keeps its own copy of the registers, predicts the RGB565 word for every
// accepted input word and compares each output word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module lmc565_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [lmc565_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [lmc565_pkg::CFG_DW-1:0]         cfg_data,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [4*lmc565_pkg::SAMPLE_W-1:0]     s_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [lmc565_pkg::TEXEL_W-1:0]        m_tdata,
    output int                                    errors,
    output int                                    pending,
    output int                                    checked,
    output int                                    overflows
);
    timeunit 1ns;
    timeprecision 1ps;

    import lmc565_pkg::*;

    logic [CFG_DW-1:0]  gain_q [4];
    logic [2:0]         maps_q;
    mode_t              mode_q;
    logic               full_q;

    logic [TEXEL_W-1:0] expected_texels [$];
    logic [TEXEL_W-1:0] want;
    bit                 over;

    int err_cnt = 0;
    int chk_cnt = 0;
    int ovf_cnt = 0;
    int pend_cnt = 0;

    assign errors    = err_cnt;
    assign pending   = pend_cnt;
    assign checked   = chk_cnt;
    assign overflows = ovf_cnt;

    function automatic logic [7:0] sat_byte(input logic [17:0] v);
        return (v > 18'd255) ? 8'hFF : v[7:0];
    endfunction

    // Weighted sum per channel, fraction dropped, then shaped by the mode
    function automatic logic [TEXEL_W-1:0] combine_texel(
        input  logic [4*SAMPLE_W-1:0] samples,
        output bit                    saturating
    );
        logic [25:0]         acc [3];
        logic [17:0]         ch [3];
        logic [17:0]         mx;
        logic [7:0]          px [3];
        logic [SAMPLE_W-1:0] smp;
        logic [CFG_DW-1:0]   gn;
        int                  n;
        n = (maps_q > 3'd4) ? 4 : int'(maps_q);
        for (int c = 0; c < 3; c++)
            acc[c] = '0;
        if (full_q)
        begin
            for (int c = 0; c < 3; c++)
                ch[c] = 18'd255;
        end
        else
        begin
            for (int m = 0; m < n; m++)
            begin
                smp = samples[m*SAMPLE_W +: SAMPLE_W];
                gn  = gain_q[m];
                for (int c = 0; c < 3; c++)
                    acc[c] += 26'(smp[16-8*c +: 8]) * 26'(gn[32-16*c +: 16]);
            end
            for (int c = 0; c < 3; c++)
                ch[c] = acc[c][25:8];
        end
        mx = ch[0];
        if (ch[1] > mx)
            mx = ch[1];
        if (ch[2] > mx)
            mx = ch[2];
        saturating = (mx > 18'd255);
        case (mode_q)
            MODE_CLAMP:
                for (int c = 0; c < 3; c++)
                    px[c] = sat_byte(ch[c]);
            MODE_GRAY:
                for (int c = 0; c < 3; c++)
                    px[c] = sat_byte(mx);
            MODE_COLOR:
                for (int c = 0; c < 3; c++)
                    px[c] = saturating ? 8'((32'(ch[c]) * 32'd255) / 32'(mx)) : ch[c][7:0];
            default:
                for (int c = 0; c < 3; c++)
                    px[c] = 8'hFF - sat_byte(mx);
        endcase
        return {px[0][7:3], px[1][7:2], px[2][7:3]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                gain_q[k] = GAIN_RESET;
            maps_q = MAPS_RESET;
            mode_q = MODE_CLAMP;
            full_q = 1'b0;
            expected_texels.delete();
            pend_cnt = 0;
        end
        else
        begin
            // Predict with the registers as they stood before this edge
            if (s_tvalid && s_tready)
            begin
                expected_texels.push_back(combine_texel(s_tdata, over));
                if (over)
                    ovf_cnt++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_texels.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t ERROR: output word %h with none expected", $time, m_tdata);
                end
                else
                begin
                    want = expected_texels.pop_front();
                    chk_cnt++;
                    if (m_tdata !== want)
                    begin
                        err_cnt++;
                        $display("%0t ERROR: texel_rgb565 expected %h actual %h",
                                 $time, want, m_tdata);
                    end
                end
            end
            if (cfg_wen)
            begin
                if (cfg_addr < REG_MAPS)
                    gain_q[cfg_addr[1:0]] = cfg_data;
                else
                    case (cfg_addr)
                        REG_MAPS: maps_q = cfg_data[2:0];
                        REG_MODE: mode_q = mode_t'(cfg_data[1:0]);
                        REG_FULL: full_q = cfg_data[0];
                        default: ;
                    endcase
            end
            pend_cnt = expected_texels.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the lightmap combiner with directed and random texels under random
// source gaps and sink stalls, reprograms gains, map count, output mode and
// full bright between phases, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lmc565_pkg::*;

    // Index past the last register; writes there must be dropped
    localparam logic [CFG_AW-1:0] REG_SPARE = 3'd7;
    localparam int                LATENCY   = 13;
    localparam int                N_TEXELS  = 450;

    localparam logic [CFG_DW-1:0] GAIN_MAX  = 48'hFFFF_FFFF_FFFF;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wen = 1'b0;
    logic [CFG_AW-1:0]        cfg_addr = '0;
    logic [CFG_DW-1:0]        cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // sample_map0 [23:0], sample_map1 [47:24], sample_map2 [71:48],
    // sample_map3 [95:72]
    logic [4*SAMPLE_W-1:0]    s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // texel_rgb565 [15:0]
    logic [TEXEL_W-1:0]       m_tdata;

    int errors;
    int pending;
    int checked;
    int overflows;

    int  sent = 0;
    int  cfg_writes = 0;
    bit  idle_on = 1'b1;
    int  hold_left = 0;

    lightmap_combine_rgb565 #(
        .MAX_MAPS(4)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    lmc565_checker u_watch (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .overflows (overflows)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Byte biased toward its extremes
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [4*SAMPLE_W-1:0] rand_texel();
        logic [4*SAMPLE_W-1:0] t;
        for (int k = 0; k < 12; k++)
            t[k*8 +: 8] = rand_byte();
        return t;
    endfunction

    // One 8.8 gain: zero, max, unity, near unity, or anything
    function automatic logic [15:0] rand_gain16();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        if (r == 2)
            return 16'h0100;
        if (r < 6)
            return 16'($urandom_range(0, 16'h0200));
        return 16'($urandom);
    endfunction

    function automatic logic [CFG_DW-1:0] rand_word48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DW-1:0];
    endfunction

    // Sink side: stall at random while idling is on, otherwise always ready
    always @(negedge clk)
    begin
        if (!idle_on)
            m_tready <= 1'b1;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            hold_left = pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    // Offer one texel, hold it until taken; entered and left at a falling edge
    task automatic push_texel(input logic [4*SAMPLE_W-1:0] samples);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= samples;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent++;
    endtask

    // Stop sending and wait until every predicted word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 3) @(negedge clk);
    endtask

    // Registers change only with the pipeline empty
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        drain();
        cfg_wen  <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wen  <= 1'b0;
        @(negedge clk);
        cfg_writes++;
    endtask

    task automatic set_all_gains(input logic [CFG_DW-1:0] val);
        for (int k = 0; k < 4; k++)
            write_reg(REG_GAIN0 + CFG_AW'(k), val);
    endtask

    initial
    begin
        mode_t md;
        int    phase_len;
        int    r;
        logic [2:0] maps;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: unity gains, map 0 only, clamp
        push_texel('0);
        push_texel({4*SAMPLE_W{1'b1}});
        push_texel(96'hA5A5A5_5A5A5A_FFFFFF_0F1E2D);

        // Max gains on all four maps, every mode: saturating white, uneven
        // channels, and a texel that lands exactly on 255 (no rescale)
        set_all_gains(GAIN_MAX);
        write_reg(REG_MAPS, CFG_DW'(4));
        md = MODE_CLAMP;
        repeat (4)
        begin
            write_reg(REG_MODE, CFG_DW'(md));
            push_texel({4*SAMPLE_W{1'b1}});
            push_texel(96'h000001_000100_010000_FF8040);
            push_texel(96'h000000_000000_000000_010101);
            md = md.next();
        end

        // Full bright ignores samples: white in clamp, black in alpha
        write_reg(REG_FULL, CFG_DW'(1));
        write_reg(REG_MODE, CFG_DW'(MODE_CLAMP));
        push_texel('0);
        write_reg(REG_MODE, CFG_DW'(MODE_ALPHA));
        push_texel({4*SAMPLE_W{1'b1}});
        write_reg(REG_FULL, CFG_DW'(0));

        // No maps summed, then a count above the map limit
        write_reg(REG_MODE, CFG_DW'(MODE_CLAMP));
        write_reg(REG_MAPS, CFG_DW'(0));
        push_texel({4*SAMPLE_W{1'b1}});
        write_reg(REG_MAPS, CFG_DW'(7));
        write_reg(REG_SPARE, GAIN_MAX);
        push_texel(96'h010203_102030_808080_FF0000);

        // Random phases: fresh registers (junk in unused upper bits), then a
        // burst of random texels; each phase boundary waits for a full drain
        while (sent < N_TEXELS)
        begin
            for (int k = 0; k < 4; k++)
                write_reg(REG_GAIN0 + CFG_AW'(k),
                          {rand_gain16(), rand_gain16(), rand_gain16()});
            r = $urandom_range(0, 9);
            if (r < 7)
                maps = 3'($urandom_range(1, 4));
            else if (r == 7)
                maps = 3'd0;
            else
                maps = 3'($urandom_range(5, 7));
            write_reg(REG_MAPS, CFG_DW'({rand_word48() >> 3, maps}));
            write_reg(REG_MODE, CFG_DW'({rand_word48() >> 2, 2'($urandom_range(0, 3))}));
            write_reg(REG_FULL, CFG_DW'({rand_word48() >> 1, ($urandom_range(0, 7) == 0)}));
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_SPARE, rand_word48());
            idle_on   = ($urandom_range(0, 4) != 0);
            phase_len = $urandom_range(5, 20);
            repeat (phase_len) push_texel(rand_texel());
        end

        // Let the pipeline empty out, bounded by the watchdog
        s_tvalid <= 1'b0;
        idle_on = 1'b1;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);

        $display("Run covered %0d texels (%0d checked) over %0d register writes.",
                 sent, checked, cfg_writes);
        $display("All four modes, full bright, 0..7 maps; %0d texels above 255 in a channel.",
                 overflows);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d words outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lmc565_pkg.sv
rtl/core/lightmap_combine_rgb565.sv
bench/lmc565_checker.sv
bench/tb_top.sv
